/* design/bounded_byte_ram_sized_access_defines.svh */
// Assertion macros used by the checker of this block.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef BOUNDED_BYTE_RAM_SIZED_ACCESS_DEFINES_SVH
`define BOUNDED_BYTE_RAM_SIZED_ACCESS_DEFINES_SVH

// same-cycle implication
`define BBRAM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbram check failed");

// next-cycle implication
`define BBRAM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbram check failed");

`endif

/* design/bbram_pkg.sv */
package bbram_pkg;

	localparam int unsigned MEM_BYTES_DEF = 65536;
	// result queue depth, also the bound on words in flight
	localparam int unsigned RES_QDEPTH = 8;

	typedef enum logic [2:0] {
		FUNC_RD8  = 3'd0,
		FUNC_RD16 = 3'd1,
		FUNC_RD32 = 3'd2,
		FUNC_WR8  = 3'd3,
		FUNC_WR16 = 3'd4,
		FUNC_WR32 = 3'd5
	} func_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        ok;
	} result_t;

	// row address width of one byte-lane bank
	function automatic int unsigned row_width(input int unsigned bytes);
		int unsigned rows;
		rows = (bytes + 3) >> 2;
		return (rows > 1) ? $clog2(rows) : 1;
	endfunction

endpackage

/* design/bounded_byte_ram_sized_access.sv */
// Byte-addressable RAM of MEM_BYTES bytes at base address cfg_data, serving 1, 2 or 4 byte
// reads and writes at any byte address, little-endian. Storage is four byte-lane RAMs, so
// an unaligned word touches each lane once and one word is taken every cycle while
// in_ready is high. Up to 8 words may be in flight, and results queue while out_ready is
// low. After reset a clearing pass writes zero to every row, with in_ready low.
// Out-of-range accesses and unused func codes return ok=0, read_data=0 and change
// nothing. Write the base only when idle.
module bounded_byte_ram_sized_access import bbram_pkg::*; #(
	parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        ok
);

	localparam int unsigned ROWS  = (MEM_BYTES + 3) / 4;
	localparam int unsigned ROW_W = row_width(MEM_BYTES);
	localparam int unsigned CNT_W = $clog2(RES_QDEPTH + 1);
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t             state_q;
	logic [ROW_W-1:0]   clr_row_q;
	logic [31:0]        base_q;
	logic [CNT_W-1:0]   inflight_q;
	logic               in_acc;
	logic               out_acc;

	// stage 1: registered request
	logic               valid_s1;
	logic [2:0]         func_s1;
	logic [31:0]        addr_s1;
	logic [31:0]        wdata_s1;
	logic               legal;
	logic               is_wr;
	logic [2:0]         size;
	logic [32:0]        diff;
	logic [32:0]        last_addr;

	// stage 2: range check and RAM issue
	logic               valid_s2;
	logic               legal_s2;
	logic               is_wr_s2;
	logic [2:0]         size_s2;
	logic [32:0]        diff_s2;
	logic               ovf_s2;
	logic [31:0]        wdata_s2;
	logic               hit;
	logic [1:0]         lane0;
	logic [ROW_W-1:0]   row;
	logic [ROW_W-1:0]   row_inc;
	logic [31:0]        echo;
	logic [ROW_W-1:0]   bank_waddr [4];
	logic [ROW_W-1:0]   bank_raddr [4];
	logic               bank_we    [4];
	logic [7:0]         bank_wdata [4];
	logic [7:0]         bank_rdata [4];

	// stage 3: RAM data back, assemble result
	logic               valid_s3;
	logic               ok_s3;
	logic               is_wr_s3;
	logic [2:0]         size_s3;
	logic [1:0]         lane_s3;
	logic [31:0]        echo_s3;
	logic [31:0]        rd_word;
	result_t            res;
	result_t            head;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_RUN) && (inflight_q < CNT_W'(RES_QDEPTH));
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_row_q  <= '0;
			base_q     <= '0;
			inflight_q <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_row_q == ROW_W'(ROWS - 1)) begin
						state_q <= ST_RUN;
					end else begin
						clr_row_q <= clr_row_q + 1'b1;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
			valid_s1   <= in_acc;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1  <= func;
			addr_s1  <= address;
			wdata_s1 <= write_data;
		end
		legal_s2 <= legal;
		is_wr_s2 <= is_wr;
		size_s2  <= size;
		diff_s2  <= diff;
		ovf_s2   <= last_addr[32];
		wdata_s2 <= wdata_s1;
		ok_s3    <= hit;
		is_wr_s3 <= is_wr_s2;
		size_s3  <= size_s2;
		lane_s3  <= lane0;
		echo_s3  <= echo;
	end

	always_comb begin
		legal = 1'b1;
		is_wr = 1'b0;
		size  = 3'd1;
		case (func_s1)
			FUNC_RD8:  size = 3'd1;
			FUNC_RD16: size = 3'd2;
			FUNC_RD32: size = 3'd4;
			FUNC_WR8: begin
				is_wr = 1'b1;
				size  = 3'd1;
			end
			FUNC_WR16: begin
				is_wr = 1'b1;
				size  = 3'd2;
			end
			FUNC_WR32: begin
				is_wr = 1'b1;
				size  = 3'd4;
			end
			default: legal = 1'b0;
		endcase
	end

	// bit 32 of diff is the borrow: address below base
	assign diff      = {1'b0, addr_s1} - {1'b0, base_q};
	// carry out means the last byte lies past the top of the address space
	assign last_addr = {1'b0, addr_s1} + 33'(size - 3'd1);

	assign hit     = valid_s2 && legal_s2 && !diff_s2[32] && !ovf_s2
	                 && ((diff_s2 + 33'(size_s2)) <= MEM_LIMIT);
	assign lane0   = diff_s2[1:0];
	assign row     = diff_s2[ROW_W+1:2];
	assign row_inc = row + 1'b1;

	always_comb begin
		case (size_s2)
			3'd1:    echo = {24'd0, wdata_s2[7:0]};
			3'd2:    echo = {16'd0, wdata_s2[15:0]};
			default: echo = wdata_s2;
		endcase
	end

	// bank b holds byte j = b - lane0 of the word; banks below lane0 sit one row up
	always_comb begin
		logic [1:0] j;
		for (int b = 0; b < 4; b++) begin
			j = 2'(2'(b) - lane0);
			bank_raddr[b] = (2'(b) < lane0) ? row_inc : row;
			if (state_q == ST_CLEAR) begin
				bank_we[b]    = 1'b1;
				bank_waddr[b] = clr_row_q;
				bank_wdata[b] = 8'd0;
			end else begin
				bank_we[b]    = hit && is_wr_s2 && ({1'b0, j} < size_s2);
				bank_waddr[b] = bank_raddr[b];
				bank_wdata[b] = wdata_s2[8*j +: 8];
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_bank
		bbram_ram #(
			.WIDTH (8),
			.DEPTH (ROWS)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[g]),
			.waddr (bank_waddr[g]),
			.wdata (bank_wdata[g]),
			.raddr (bank_raddr[g]),
			.rdata (bank_rdata[g])
		);
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < size_s3) begin
				rd_word[8*k +: 8] = bank_rdata[2'(lane_s3 + 2'(k))];
			end else begin
				rd_word[8*k +: 8] = 8'd0;
			end
		end
		res.ok = ok_s3;
		if (!ok_s3) begin
			res.read_data = '0;
		end else if (is_wr_s3) begin
			res.read_data = echo_s3;
		end else begin
			res.read_data = rd_word;
		end
	end

	bbram_fifo #(
		.DEPTH (RES_QDEPTH)
	) u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (valid_s3),
		.push_data  (res),
		.pop        (out_ready),
		.head_valid (out_valid),
		.head_data  (head)
	);

	assign read_data = head.read_data;
	assign ok        = head.ok;

endmodule

/* design/bbram_ram.sv */
module bbram_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/bbram_fifo.sv */
module bbram_fifo import bbram_pkg::*; #(
	parameter int unsigned DEPTH = RES_QDEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    head_valid,
	output result_t head_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	result_t        slot_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_pop;

	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(do_pop);
		end
	end

endmodule

/* design/bbram_checker.sv */
`include "bounded_byte_ram_sized_access_defines.svh"

module bbram_checker import bbram_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_data,
	input logic        ok
);

	localparam int unsigned PEND_W = $clog2(RES_QDEPTH + 2);

	logic [PEND_W-1:0] pend_q;

	// words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + PEND_W'(in_valid && in_ready) - PEND_W'(out_valid && out_ready);
		end
	end

	`BBRAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(ok))
	`BBRAM_ASSERT_NOW(a_fail_zero, out_valid && !ok, read_data == 32'd0)
	`BBRAM_ASSERT_NOW(a_no_extra, out_valid, pend_q != '0)
	`BBRAM_ASSERT_NOW(a_bounded, in_valid && in_ready, pend_q < PEND_W'(RES_QDEPTH))

endmodule

bind bounded_byte_ram_sized_access bbram_checker u_bbram_checker (.*);

/* sim/bbram_access_tracker.sv */
module bbram_access_tracker import bbram_pkg::*; #(
	parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] read_data,
	input  logic        ok,
	output int          outstanding,
	output int          failures
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  ram_image [0:MEM_BYTES-1];
	logic [31:0] ram_base;
	result_t     expected_results [$];
	result_t     oldest;
	int          fail_count;

	// Applies one access to the byte image and returns the word the RAM should answer with.
	function automatic result_t access_outcome(input logic [2:0] f, input logic [31:0] a,
			input logic [31:0] wd);
		result_t         r;
		longint unsigned span;
		longint unsigned off;
		bit              is_wr;
		int              i;
		r = '0;
		is_wr = 1'b0;
		case (f)
		FUNC_RD8:  span = 1;
		FUNC_RD16: span = 2;
		FUNC_RD32: span = 4;
		FUNC_WR8: begin
			span = 1;
			is_wr = 1'b1;
		end
		FUNC_WR16: begin
			span = 2;
			is_wr = 1'b1;
		end
		FUNC_WR32: begin
			span = 4;
			is_wr = 1'b1;
		end
		default: return r;
		endcase
		// bounds checked in 64 bits, no wrap past the top of the address space
		if (a < ram_base)
			return r;
		if (64'(a) + span > 64'h1_0000_0000)
			return r;
		off = 64'(a) - 64'(ram_base);
		if (off + span > 64'(MEM_BYTES))
			return r;
		for (i = 0; i < int'(span); i++) begin
			if (is_wr) begin
				ram_image[off + i] = wd[8*i +: 8];
				r.read_data[8*i +: 8] = wd[8*i +: 8];
			end else begin
				r.read_data[8*i +: 8] = ram_image[off + i];
			end
		end
		r.ok = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_base = '0;
			fail_count = 0;
			expected_results.delete();
			foreach (ram_image[k])
				ram_image[k] = '0;
			outstanding <= 0;
			failures <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no access pending: read_data %h ok %b",
						read_data, ok);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (read_data !== oldest.read_data) begin
						$error("read_data: expected %h, got %h", oldest.read_data, read_data);
						fail_count++;
					end
					if (ok !== oldest.ok) begin
						$error("ok: expected %b, got %b", oldest.ok, ok);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					access_outcome(func, address, write_data));
			if (cfg_valid && cfg_ready)
				ram_base = cfg_data;
			outstanding <= expected_results.size();
			failures <= fail_count;
		end
	end

endmodule

/* sim/bounded_byte_ram_sized_access_test.sv */
module bounded_byte_ram_sized_access_test import bbram_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RAM_BYTES = MEM_BYTES_DEF;
	localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
	localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
	localparam int QUIET_LIMIT = 60000;
	localparam int PHASE_ITEMS = 210;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic [31:0] address;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_data;
	logic        ok;
	int          outstanding;
	int          failures;

	int send_gap;
	int recv_stall;
	int quiet_cycles;
	int access_count;
	int base_writes;

	bounded_byte_ram_sized_access #(.MEM_BYTES(RAM_BYTES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.address   (address),
		.write_data(write_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.ok        (ok)
	);

	bbram_access_tracker #(.MEM_BYTES(RAM_BYTES)) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.address    (address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.ok         (ok),
		.outstanding(outstanding),
		.failures   (failures)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// clearing pass after reset holds in_ready low
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
				(out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_access(input logic [2:0] f, input logic [31:0] a,
			input logic [31:0] wd);
		@(negedge clk);
		while ($urandom_range(99) < send_gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		address <= a;
		write_data <= wd;
		do @(posedge clk); while (!in_ready);
		access_count++;
	endtask

	// drop valid and wait until every issued access has answered
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_base(input logic [31:0] b);
		drain();
		repeat (6) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= b;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		base_writes++;
	endtask

	// mostly hits a small hot window and both ends of the RAM so reads see written bytes
	task automatic random_access(input logic [31:0] b);
		logic [2:0]  f;
		logic [31:0] a;
		logic [31:0] wd;
		if ($urandom_range(19) == 0)
			f = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
		else
			f = 3'($urandom_range(FUNC_WR32));
		case ($urandom_range(15))
		0, 1, 2, 3, 4, 5, 6, 7: a = b + 32'($urandom_range(63));
		8, 9:                   a = b + 32'($urandom_range(7));
		10, 11:                 a = b + 32'(RAM_BYTES) - 32'd1 - 32'($urandom_range(7));
		12:                     a = b + ($urandom % RAM_BYTES);
		13:                     a = b - 32'd1 - 32'($urandom_range(3));
		14:                     a = b + 32'(RAM_BYTES) + 32'($urandom_range(3));
		default:                a = $urandom;
		endcase
		case ($urandom_range(15))
		0:       wd = '0;
		1:       wd = '1;
		default: wd = $urandom;
		endcase
		send_access(f, a, wd);
	endtask

	initial begin
		logic [31:0] phase_base;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_RD8;
		address = '0;
		write_data = '0;
		out_ready = 1'b0;
		send_gap = 7;
		recv_stall = 57;
		quiet_cycles = 0;
		access_count = 0;
		base_writes = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		write_base(32'h0);
		send_access(FUNC_RD32, 32'h0, 32'h0);            // cleared store reads zero
		send_access(FUNC_WR32, 32'h0, 32'hFFFF_FFFF);
		send_access(FUNC_RD16, 32'h1, 32'h0);            // unaligned
		send_access(FUNC_WR8, 32'h3, 32'h1234_5678);
		send_access(FUNC_RD32, 32'h0, 32'h0);
		send_access(FUNC_WR16, 32'h0000_FFFF, 32'hABCD_1357); // straddles the end
		send_access(FUNC_WR8, 32'h0000_FFFF, 32'h0000_00C3);
		send_access(FUNC_RD32, 32'h0000_FFFC, 32'h0);     // last full word
		send_access(FUNC_RD32, 32'h0000_FFFD, 32'h0);     // one byte past the end
		send_access(FUNC_UNUSED_LO, 32'h0, 32'hFFFF_FFFF);
		send_access(FUNC_UNUSED_HI, 32'h0, 32'hFFFF_FFFF);
		send_access(FUNC_WR32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_access(FUNC_RD8, 32'hFFFF_FFFF, 32'h0);
		send_access(FUNC_WR32, 32'h0000_0101, 32'hDEAD_BEEF);
		send_access(FUNC_RD16, 32'h0000_0102, 32'h0);
		send_access(FUNC_RD8, 32'h0000_0104, 32'h0);
		send_access(FUNC_WR16, 32'h0000_0200, 32'h0000_0000);
		send_access(FUNC_RD16, 32'h0000_0200, 32'h0);

		// only the single byte at the top of the address space is mapped
		write_base(32'hFFFF_FFFF);
		send_access(FUNC_RD8, 32'hFFFF_FFFF, 32'h0);
		send_access(FUNC_WR16, 32'hFFFF_FFFF, 32'h5A5A_5A5A); // wraps past 2^32
		send_access(FUNC_WR8, 32'hFFFF_FFFF, 32'h0000_0000);
		send_access(FUNC_RD32, 32'hFFFF_FFFC, 32'h0);
		send_access(FUNC_RD8, 32'hFFFF_FFFE, 32'h0);

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				phase_base = 32'hFFFF_0000;   // window ends exactly at 2^32
				send_gap = 7;
				recv_stall = 57;
			end
			1: begin
				phase_base = $urandom;
				send_gap = 57;
				recv_stall = 7;
			end
			2: begin
				phase_base = 32'hFFFF_8000;   // window would run past 2^32
				send_gap = 0;
				recv_stall = 0;
			end
			default: begin
				phase_base = 32'h0;
				send_gap = 0;
				recv_stall = 0;
			end
			endcase
			write_base(phase_base);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2)
					drain();
				random_access(phase_base);
			end
		end

		drain();
		repeat (12) @(negedge clk);
		$display("%0d accesses over %0d base settings, sizes 1/2/4 at edges and off the map,",
			access_count, base_writes);
		$display("with sender and receiver stalls swapped and a back-to-back stretch");
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* bounded_byte_ram_sized_access.f */
+incdir+design
design/bbram_pkg.sv
design/bbram_ram.sv
design/bbram_fifo.sv
design/bounded_byte_ram_sized_access.sv
design/bbram_checker.sv
sim/bbram_access_tracker.sv
sim/bounded_byte_ram_sized_access_test.sv
